### rtl/swtr_pkg.sv
// ----------------------------------------------------------------------------
// swtr_pkg
// Shared types and constants for the sliding-window trend regression core.
// ----------------------------------------------------------------------------
`default_nettype none

package swtr_pkg;

  localparam int MAX_LEN_DEF = 512;
  localparam int NCH         = 4;
  localparam int SMP_W       = 16;
  localparam int ENTRY_W     = NCH * SMP_W;
  localparam int NW          = 10;   // point count / window width
  localparam int SY_W        = 26;
  localparam int SXY_W       = 34;
  localparam int P1_W        = SY_W + NW + 1;
  localparam int P2_W        = SY_W + NW + 3;
  localparam int D_W         = 37;
  localparam int NUM_S_W     = 56;
  localparam int NUM_I_W     = 40;
  localparam int DEN_S_W     = 30;
  localparam int DEN_I_W     = 20;
  localparam int SLOPE_W     = 32;
  localparam int ICPT_W      = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [NW-1:0] WINDOW_RESET = 10'd50;
  localparam logic [0:0]    REG_WINDOW   = 1'b0;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_RECOMPUTE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_UPD,
    S_REC_INIT,
    S_REC_RUN,
    S_REC_DRAIN,
    S_FIT_A,
    S_FIT_B,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take_in;
    logic app_rd;
    logic app_upd;
    logic clr_hist;
    logic rec_init;
    logic rec_step;
    logic fit_a;
    logic fit_b;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_lt2;
    logic rec_last;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/swtr_ram.sv
// ----------------------------------------------------------------------------
// swtr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swtr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/swtr_div.sv
// ----------------------------------------------------------------------------
// swtr_div
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero: q = (2|num| + den) / (2 den), sign of num.
// ----------------------------------------------------------------------------
`default_nettype none

module swtr_div #(
  parameter int NUMW = 56,
  parameter int DENW = 30
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [NUMW-1:0] num,
  input  wire logic [DENW-1:0]        den,
  output logic                        busy,
  output logic signed [NUMW+1:0]      quot
);

  localparam int DVW  = NUMW + 1;
  localparam int RW   = DENW + 2;
  localparam int CNTW = $clog2(DVW + 1);

  logic [CNTW-1:0] cnt;
  logic [DVW-1:0]  dvd;
  logic [RW-1:0]   rem;
  logic [DENW:0]   dv2;
  logic            neg;

  logic [NUMW-1:0] mag;
  logic [DVW-1:0]  dividend;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   rem_next;
  logic            qbit;

  always_comb begin
    mag      = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    dividend = {mag, 1'b0} + DVW'(den);
    rem_sh   = {rem[RW-2:0], dvd[DVW-1]};
    qbit     = rem_sh >= {1'b0, dv2};
    rem_next = qbit ? rem_sh - {1'b0, dv2} : rem_sh;
    quot     = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DVW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dv2 <= {den, 1'b0};
      neg <= num[NUMW-1];
    end else if (busy) begin
      dvd <= {dvd[DVW-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

### rtl/swtr_datapath.sv
// ----------------------------------------------------------------------------
// swtr_datapath
// Sample history, running sums, fit numerators and dividers, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module swtr_datapath #(
  parameter int MAX_LEN = swtr_pkg::MAX_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire swtr_pkg::cmd_t                    cmd,
  output swtr_pkg::sts_t                         sts,
  input  wire logic [swtr_pkg::NW-1:0]           window,
  input  wire logic signed [swtr_pkg::SMP_W-1:0] sample [swtr_pkg::NCH],
  output logic signed [swtr_pkg::SLOPE_W-1:0]    slope [swtr_pkg::NCH],
  output logic signed [swtr_pkg::ICPT_W-1:0]     icpt [swtr_pkg::NCH],
  output logic                                   trend_valid,
  output logic [swtr_pkg::NW-1:0]                points
);

  import swtr_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int TW = AW + NW + 1;
  localparam int SQW = 2 * NW;
  localparam int QSW = NUM_S_W + 2;
  localparam int QIW = NUM_I_W + 2;

  function automatic logic [AW-1:0] back_idx(input logic [AW-1:0] p,
                                             input logic [NW-1:0] k);
    logic [TW-1:0] t;
    t = TW'(p) + TW'(MAX_LEN) - TW'(k);
    if (t >= TW'(MAX_LEN)) begin
      t = t - TW'(MAX_LEN);
    end
    return AW'(t);
  endfunction

  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr;
  logic [NW-1:0] x;
  logic [NW-1:0] x_d;
  logic          acc_v;
  logic signed [SMP_W-1:0] smp [NCH];
  logic signed [SY_W-1:0]  sum_y [NCH];
  logic signed [SXY_W-1:0] sum_xy [NCH];

  logic [NW-1:0] w_eff;
  logic [NW-1:0] n_cur;
  logic          full;

  always_comb begin
    if (window == '0) begin
      w_eff = NW'(1);
    end else if (int'(window) > MAX_LEN) begin
      w_eff = NW'(MAX_LEN);
    end else begin
      w_eff = window;
    end
    full  = !(int'(count) < int'(w_eff));
    n_cur = full ? w_eff : NW'(count);
  end

  // History memory
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;

  always_comb begin
    raddr = cmd.app_rd ? back_idx(wr_ptr, n_cur) : back_idx(wr_ptr, n_cur - x);
    for (int c = 0; c < NCH; c++) begin
      wdata[c*SMP_W +: SMP_W] = smp[c];
    end
  end

  swtr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_LEN)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.app_upd),
    .waddr(wr_ptr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Append update terms
  logic [NW-1:0]                 factor;
  logic signed [SMP_W+NW:0]      app_prod [NCH];
  logic signed [SMP_W+NW:0]      rec_prod [NCH];
  logic signed [SMP_W-1:0]       old_v [NCH];
  logic signed [SMP_W-1:0]       rec_v [NCH];
  logic signed [SY_W-1:0]        sy_app [NCH];
  logic signed [SXY_W-1:0]       sxy_app [NCH];

  always_comb begin
    factor = full ? w_eff - 1'b1 : n_cur;
    for (int c = 0; c < NCH; c++) begin
      old_v[c]    = $signed(rdata[c*SMP_W +: SMP_W]);
      rec_v[c]    = old_v[c];
      app_prod[c] = $signed({1'b0, factor}) * smp[c];
      rec_prod[c] = $signed({1'b0, x_d}) * rec_v[c];
      if (full) begin
        sxy_app[c] = sum_xy[c] + SXY_W'(app_prod[c]) + SXY_W'(old_v[c])
                     - SXY_W'(sum_y[c]);
        sy_app[c]  = sum_y[c] + SY_W'(smp[c]) - SY_W'(old_v[c]);
      end else begin
        sxy_app[c] = sum_xy[c] + SXY_W'(app_prod[c]);
        sy_app[c]  = sum_y[c] + SY_W'(smp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      smp <= sample;
    end
    x_d <= x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      x      <= '0;
      acc_v  <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        sum_y[c]  <= '0;
        sum_xy[c] <= '0;
      end
    end else begin
      acc_v <= cmd.rec_step;
      if (cmd.clr_hist) begin
        count <= '0;
      end
      if (cmd.clr_hist || cmd.rec_init) begin
        x <= '0;
        for (int c = 0; c < NCH; c++) begin
          sum_y[c]  <= '0;
          sum_xy[c] <= '0;
        end
      end else if (cmd.app_upd) begin
        wr_ptr <= (wr_ptr == AW'(MAX_LEN - 1)) ? '0 : wr_ptr + 1'b1;
        if (count != CW'(MAX_LEN)) begin
          count <= count + 1'b1;
        end
        sum_y  <= sy_app;
        sum_xy <= sxy_app;
      end else if (acc_v) begin
        for (int c = 0; c < NCH; c++) begin
          sum_y[c]  <= sum_y[c] + SY_W'(rec_v[c]);
          sum_xy[c] <= sum_xy[c] + SXY_W'(rec_prod[c]);
        end
      end
      if (cmd.rec_step) begin
        x <= x + 1'b1;
      end
    end
  end

  // Fit numerators and denominators
  logic [SQW-1:0]            nsq;
  logic signed [P1_W-1:0]    p1 [NCH];
  logic signed [P2_W-1:0]    p2 [NCH];
  logic [DEN_S_W-1:0]        den_s;
  logic [DEN_I_W-1:0]        den_i;
  logic signed [NUM_S_W-1:0] num_s [NCH];
  logic signed [NUM_I_W-1:0] num_i [NCH];
  logic [NW-1:0]             nm1;
  logic [NW+1:0]             f4;

  always_comb begin
    nm1 = n_cur - 1'b1;
    f4  = {n_cur, 2'b00} - (NW+2)'(2);
  end

  function automatic logic signed [NUM_S_W-1:0] num_s_c(
      input logic signed [SXY_W-1:0] sxy, input logic signed [P1_W-1:0] pp);
    logic signed [D_W-1:0]    d;
    logic signed [NUM_I_W-1:0] d6;
    d  = {{(D_W-SXY_W-1){sxy[SXY_W-1]}}, sxy, 1'b0} - pp;
    d6 = {{(NUM_I_W-D_W-2){d[D_W-1]}}, d, 2'b00}
         + {{(NUM_I_W-D_W-1){d[D_W-1]}}, d, 1'b0};
    return {d6, 16'h0000};
  endfunction

  function automatic logic signed [NUM_I_W-1:0] num_i_c(
      input logic signed [SXY_W-1:0] sxy, input logic signed [P2_W-1:0] pp);
    logic signed [NUM_I_W-1:0] s6;
    s6 = {{(NUM_I_W-SXY_W-2){sxy[SXY_W-1]}}, sxy, 2'b00}
         + {{(NUM_I_W-SXY_W-1){sxy[SXY_W-1]}}, sxy, 1'b0};
    return {{(NUM_I_W-P2_W){pp[P2_W-1]}}, pp} - s6;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.fit_a) begin
      nsq <= SQW'(n_cur) * SQW'(n_cur);
      for (int c = 0; c < NCH; c++) begin
        p1[c] <= $signed({1'b0, nm1}) * sum_y[c];
        p2[c] <= $signed({1'b0, f4}) * sum_y[c];
      end
    end
    if (cmd.fit_b) begin
      den_s <= DEN_S_W'(DEN_S_W'(n_cur) * DEN_S_W'(nsq - SQW'(1)));
      den_i <= DEN_I_W'(nsq + SQW'(n_cur));
      for (int c = 0; c < NCH; c++) begin
        num_s[c] <= num_s_c(sum_xy[c], p1[c]);
        num_i[c] <= num_i_c(sum_xy[c], p2[c]);
      end
    end
  end

  // Dividers, one slope and one intercept unit per channel
  logic signed [QSW-1:0] q_s [NCH];
  logic signed [QIW-1:0] q_i [NCH];
  logic [2*NCH-1:0]      busy_v;

  for (genvar g = 0; g < NCH; g++) begin : g_div
    swtr_div #(
      .NUMW(NUM_S_W),
      .DENW(DEN_S_W)
    ) u_div_s (
      .clk  (clk),
      .rst  (rst),
      .start(cmd.div_start),
      .num  (num_s[g]),
      .den  (den_s),
      .busy (busy_v[2*g]),
      .quot (q_s[g])
    );
    swtr_div #(
      .NUMW(NUM_I_W),
      .DENW(DEN_I_W)
    ) u_div_i (
      .clk  (clk),
      .rst  (rst),
      .start(cmd.div_start),
      .num  (num_i[g]),
      .den  (den_i),
      .busy (busy_v[2*g+1]),
      .quot (q_i[g])
    );
  end

  // Saturate and load result registers
  logic signed [SLOPE_W-1:0] slope_sat [NCH];
  logic signed [ICPT_W-1:0]  icpt_sat [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (q_s[c][QSW-1:SLOPE_W-1] == '0 || q_s[c][QSW-1:SLOPE_W-1] == '1) begin
        slope_sat[c] = q_s[c][SLOPE_W-1:0];
      end else begin
        slope_sat[c] = {q_s[c][QSW-1], {(SLOPE_W-1){!q_s[c][QSW-1]}}};
      end
      if (q_i[c][QIW-1:ICPT_W-1] == '0 || q_i[c][QIW-1:ICPT_W-1] == '1) begin
        icpt_sat[c] = q_i[c][ICPT_W-1:0];
      end else begin
        icpt_sat[c] = {q_i[c][QIW-1], {(ICPT_W-1){!q_i[c][QIW-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      points      <= n_cur;
      trend_valid <= !sts.n_lt2;
      for (int c = 0; c < NCH; c++) begin
        slope[c] <= sts.n_lt2 ? '0 : slope_sat[c];
        icpt[c]  <= sts.n_lt2 ? '0 : icpt_sat[c];
      end
    end
  end

  always_comb begin
    sts.n_zero   = n_cur == '0;
    sts.n_lt2    = n_cur < NW'(2);
    sts.rec_last = x == nm1;
    sts.div_busy = |busy_v;
  end

endmodule

`default_nettype wire

### rtl/swtr_ctrl.sv
// ----------------------------------------------------------------------------
// swtr_ctrl
// Sequencer for append, clear, recompute and the fit, plus output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module swtr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     opcode,
  output logic                out_valid,
  input  wire logic           out_ready,
  output swtr_pkg::cmd_t      cmd,
  input  wire swtr_pkg::sts_t sts
);

  import swtr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          case (opcode)
            OP_APPEND: begin
              state_next = S_APP_RD;
            end
            OP_CLEAR: begin
              cmd.clr_hist = 1'b1;
              state_next   = S_FIT_A;
            end
            OP_RECOMPUTE: begin
              state_next = S_REC_INIT;
            end
            default: begin
              state_next = S_FIT_A;
            end
          endcase
        end
      end
      S_APP_RD: begin
        cmd.app_rd = 1'b1;
        state_next = S_APP_UPD;
      end
      S_APP_UPD: begin
        cmd.app_upd = 1'b1;
        state_next  = S_FIT_A;
      end
      S_REC_INIT: begin
        cmd.rec_init = 1'b1;
        state_next   = sts.n_zero ? S_FIT_A : S_REC_RUN;
      end
      S_REC_RUN: begin
        cmd.rec_step = 1'b1;
        if (sts.rec_last) begin
          state_next = S_REC_DRAIN;
        end
      end
      S_REC_DRAIN: begin
        state_next = S_FIT_A;
      end
      S_FIT_A: begin
        cmd.fit_a  = 1'b1;
        state_next = sts.n_lt2 ? S_DONE : S_FIT_B;
      end
      S_FIT_B: begin
        cmd.fit_b  = 1'b1;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sliding_window_trend_regression_core.sv
// An append reads the history and updates the sums, then runs the fit; an unused
// opcode runs the fit alone; a recompute first re-sums the n points in the window;
// clear empties the history. With fewer than two points no fit runs. Each fit
// waits on the 57-step slope divider. One transaction at a time: the next is
// taken the cycle after the result loads; a held result stalls.
// Reset (rst, synchronous): empties the window, zeroes the sums, window 50.
// ----------------------------------------------------------------------------
// sliding_window_trend_regression_core
// Four-channel sliding-window least-squares trend fit with APB window control.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_trend_regression_core #(
  parameter int MAX_LEN = swtr_pkg::MAX_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // APB register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [swtr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [swtr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [swtr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  // Input transaction
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          opcode,
  input  wire logic signed [swtr_pkg::SMP_W-1:0]   sample_dx,
  input  wire logic signed [swtr_pkg::SMP_W-1:0]   sample_dy,
  input  wire logic signed [swtr_pkg::SMP_W-1:0]   sample_ra,
  input  wire logic signed [swtr_pkg::SMP_W-1:0]   sample_dec,
  // Result transaction
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [swtr_pkg::SLOPE_W-1:0]      slope_dx,
  output logic signed [swtr_pkg::ICPT_W-1:0]       intercept_dx,
  output logic signed [swtr_pkg::SLOPE_W-1:0]      slope_dy,
  output logic signed [swtr_pkg::ICPT_W-1:0]       intercept_dy,
  output logic signed [swtr_pkg::SLOPE_W-1:0]      slope_ra,
  output logic signed [swtr_pkg::ICPT_W-1:0]       intercept_ra,
  output logic signed [swtr_pkg::SLOPE_W-1:0]      slope_dec,
  output logic signed [swtr_pkg::ICPT_W-1:0]       intercept_dec,
  output logic                                     trend_valid,
  output logic [swtr_pkg::NW-1:0]                  points_in_window
);

  import swtr_pkg::*;

  // Window length register; one word, selected by the word index bit.
  logic [NW-1:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW) begin
      window <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    pready = 1'b1;
    prdata = (paddr[2] == REG_WINDOW) ? CFG_DATA_W'(window) : '0;
  end

  // Controller and datapath talk only through the command and status groups.
  cmd_t cmd;
  sts_t sts;

  logic signed [SMP_W-1:0]   sample [NCH];
  logic signed [SLOPE_W-1:0] slope [NCH];
  logic signed [ICPT_W-1:0]  icpt [NCH];

  // Channel order matches the history word: dx, dy, RA, Dec from the bottom.
  always_comb begin
    sample[0] = sample_dx;
    sample[1] = sample_dy;
    sample[2] = sample_ra;
    sample[3] = sample_dec;
  end

  assign slope_dx      = slope[0];
  assign intercept_dx  = icpt[0];
  assign slope_dy      = slope[1];
  assign intercept_dy  = icpt[1];
  assign slope_ra      = slope[2];
  assign intercept_ra  = icpt[2];
  assign slope_dec     = slope[3];
  assign intercept_dec = icpt[3];

  swtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swtr_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .window     (window),
    .sample     (sample),
    .slope      (slope),
    .icpt       (icpt),
    .trend_valid(trend_valid),
    .points     (points_in_window)
  );

endmodule

`default_nettype wire
